// File: hdl/sra_pkg.sv
// ----------------------------------------------------------------------------
// sra_pkg
// Shared constants, types and the distance table builder for the station
// signal-strength table.
// ----------------------------------------------------------------------------
package sra_pkg;

   localparam int DEF_MAX_STATIONS    = 64;
   localparam int DEF_MAX_READINGS    = 10;
   localparam int DEF_EXPONENT_TENTHS = 30;

   localparam int MAC_W   = 48;
   localparam int RSSI_W  = 8;
   localparam int SUM_W   = 12;
   localparam int CNT_W   = 4;
   localparam int DIST_W  = 22;
   localparam int CSR_W   = 8;
   localparam int CSR_IDX_W = 1;
   localparam int ENTRY_W = MAC_W + SUM_W + CNT_W;

   localparam logic [CSR_IDX_W-1:0] CSR_TX_POWER  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATH_LOSS = 1'b1;

   localparam logic signed [RSSI_W-1:0] TX_POWER_RESET  = 8'sd20;
   localparam logic [CSR_W-1:0]         PATH_LOSS_RESET = 8'd40;

   localparam int DB_CLAMP  = 120;
   localparam int ROM_DEPTH = 2 * DB_CLAMP + 1;
   localparam logic [DIST_W-1:0] DIST_MAX = 22'h3FFFFF;

   // one quotient bit per step over the sum magnitude
   localparam int DIV_STEPS = SUM_W;
   localparam int DIV_CNT_W = 4;

   typedef logic [DIST_W-1:0] dist_rom_type [0:ROM_DEPTH-1];

   typedef struct packed {
      logic load_req;
      logic cap_entry;
      logic wr_insert;
      logic div_init;
      logic div_step;
      logic clamp_load;
      logic out_load;
      logic out_empty;
      logic out_last;
   } sra_cmd_type;

   typedef struct packed {
      logic key_match;
      logic upd_ok;
   } sra_status_type;

   // 256 * 10^(x * step), step being one over the exponent in tenths;
   // rounded, saturated
   function automatic dist_rom_type build_dist_rom(input real step);
      dist_rom_type rom;
      real          r;
      for (int i = 0; i < ROM_DEPTH; i++) begin
         r = 256.0 * (10.0 ** (real'(i - DB_CLAMP) * step));
         if (r >= real'(DIST_MAX)) begin
            rom[i] = DIST_MAX;
         end else begin
            rom[i] = DIST_W'($rtoi(r + 0.5));
         end
      end
      return rom;
   endfunction

endpackage

// File: hdl/station_rssi_average_ranging.sv
// Sample item: key search reads one table entry per cycle from the station RAM.
// Dump item: per station a RAM read, a 12-step serial divide, a clamp and a table
//   lookup, one result beat per station; an empty table gives one beat.
// Results are strobed for one cycle and cannot be held off.
// Reset clears the station count and restores the two registers; RAM is not cleared.
// ----------------------------------------------------------------------------
// station_rssi_average_ranging
// Per-station signal-strength averaging with log-distance range estimate.
// ----------------------------------------------------------------------------
module station_rssi_average_ranging #(
   parameter int MAX_STATIONS    = sra_pkg::DEF_MAX_STATIONS,
   parameter int MAX_READINGS    = sra_pkg::DEF_MAX_READINGS,
   parameter int EXPONENT_TENTHS = sra_pkg::DEF_EXPONENT_TENTHS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_op,
   input  logic [sra_pkg::MAC_W-1:0]         req_mac,
   input  logic                              req_rssi_present,
   input  logic signed [sra_pkg::RSSI_W-1:0] req_rssi_dbm,
   input  logic                              csr_we,
   input  logic [sra_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sra_pkg::CSR_W-1:0]         csr_wdata,
   output logic                              rsp_strobe,
   output logic [sra_pkg::MAC_W-1:0]         rsp_station_mac,
   output logic                              rsp_station_valid,
   output logic [sra_pkg::CNT_W-1:0]         rsp_samples_held,
   output logic                              rsp_has_samples,
   output logic signed [sra_pkg::RSSI_W-1:0] rsp_avg_rssi_dbm,
   output logic [sra_pkg::DIST_W-1:0]        rsp_distance_q8,
   output logic                              rsp_last
);
   import sra_pkg::*;

   localparam int AW = MAX_STATIONS > 1 ? $clog2(MAX_STATIONS) : 1;

   sra_cmd_type        cmd;
   sra_status_type     status;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;

   sra_ctrl #(
      .MAX_STATIONS (MAX_STATIONS)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_op  (req_op),
      .busy    (busy),
      .status  (status),
      .cmd     (cmd),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr)
   );

   sra_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_STATIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sra_datapath #(
      .MAX_READINGS    (MAX_READINGS),
      .EXPONENT_TENTHS (EXPONENT_TENTHS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_mac           (req_mac),
      .req_rssi_present  (req_rssi_present),
      .req_rssi_dbm      (req_rssi_dbm),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rd_data           (rd_data),
      .wr_data           (wr_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_station_mac   (rsp_station_mac),
      .rsp_station_valid (rsp_station_valid),
      .rsp_samples_held  (rsp_samples_held),
      .rsp_has_samples   (rsp_has_samples),
      .rsp_avg_rssi_dbm  (rsp_avg_rssi_dbm),
      .rsp_distance_q8   (rsp_distance_q8),
      .rsp_last          (rsp_last)
   );

endmodule

// File: hdl/sra_ram.sv
// ----------------------------------------------------------------------------
// sra_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/sra_ctrl.sv
// ----------------------------------------------------------------------------
// sra_ctrl
// Sequencer: key search, insert, update and the per-station dump walk.
// ----------------------------------------------------------------------------
module sra_ctrl #(
   parameter int MAX_STATIONS = sra_pkg::DEF_MAX_STATIONS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_op,
   output logic                    busy,
   input  sra_pkg::sra_status_type status,
   output sra_pkg::sra_cmd_type    cmd,
   output logic                    wr_en,
   output logic [(MAX_STATIONS > 1 ? $clog2(MAX_STATIONS) : 1)-1:0] wr_addr,
   output logic [(MAX_STATIONS > 1 ? $clog2(MAX_STATIONS) : 1)-1:0] rd_addr
);
   import sra_pkg::*;

   localparam int AW = MAX_STATIONS > 1 ? $clog2(MAX_STATIONS) : 1;
   localparam int CW = $clog2(MAX_STATIONS + 1);
   localparam logic [CW-1:0] MAX_USED = CW'(MAX_STATIONS);

   typedef enum logic [9:0] {
      ST_IDLE       = 10'b00_0000_0001,
      ST_SEARCH     = 10'b00_0000_0010,
      ST_INSERT     = 10'b00_0000_0100,
      ST_UPDATE     = 10'b00_0000_1000,
      ST_DUMP_RD    = 10'b00_0001_0000,
      ST_DUMP_LOAD  = 10'b00_0010_0000,
      ST_DUMP_DIV   = 10'b00_0100_0000,
      ST_DUMP_CLAMP = 10'b00_1000_0000,
      ST_DUMP_OUT   = 10'b01_0000_0000,
      ST_DUMP_EMPTY = 10'b10_0000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        used_ff, used_in;
   logic [AW-1:0]        cmp_idx_ff, cmp_idx_in;
   logic                 pend_ff, pend_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 dump_last;

   assign busy      = (state_ff != ST_IDLE);
   assign rd_addr   = idx_ff[AW-1:0];
   assign dump_last = ((idx_ff + CW'(1)) == used_ff);

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      used_in    = used_ff;
      cmp_idx_in = cmp_idx_ff;
      pend_in    = pend_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      wr_en      = 1'b0;
      wr_addr    = cmp_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               idx_in       = '0;
               pend_in      = 1'b0;
               if (!req_op) begin
                  state_in = ST_SEARCH;
               end else if (used_ff == '0) begin
                  state_in = ST_DUMP_EMPTY;
               end else begin
                  state_in = ST_DUMP_RD;
               end
            end
         end
         ST_SEARCH: begin
            // compare the beat read last cycle while the next read goes out
            if (pend_ff && status.key_match) begin
               cmd.cap_entry = 1'b1;
               pend_in       = 1'b0;
               state_in      = ST_UPDATE;
            end else if (!pend_ff && idx_ff == used_ff) begin
               state_in = (used_ff == MAX_USED) ? ST_IDLE : ST_INSERT;
            end else if (idx_ff < used_ff) begin
               cmp_idx_in = idx_ff[AW-1:0];
               idx_in     = idx_ff + CW'(1);
               pend_in    = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_INSERT: begin
            cmd.wr_insert = 1'b1;
            wr_en         = 1'b1;
            wr_addr       = used_ff[AW-1:0];
            used_in       = used_ff + CW'(1);
            state_in      = ST_IDLE;
         end
         ST_UPDATE: begin
            wr_en    = status.upd_ok;
            state_in = ST_IDLE;
         end
         ST_DUMP_RD: begin
            state_in = ST_DUMP_LOAD;
         end
         ST_DUMP_LOAD: begin
            cmd.cap_entry = 1'b1;
            cmd.div_init  = 1'b1;
            div_cnt_in    = '0;
            state_in      = ST_DUMP_DIV;
         end
         ST_DUMP_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DUMP_CLAMP;
            end
         end
         ST_DUMP_CLAMP: begin
            cmd.clamp_load = 1'b1;
            state_in       = ST_DUMP_OUT;
         end
         ST_DUMP_OUT: begin
            cmd.out_load = 1'b1;
            cmd.out_last = dump_last;
            idx_in       = idx_ff + CW'(1);
            state_in     = dump_last ? ST_IDLE : ST_DUMP_RD;
         end
         ST_DUMP_EMPTY: begin
            cmd.out_load  = 1'b1;
            cmd.out_empty = 1'b1;
            cmd.out_last  = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         idx_ff     <= '0;
         used_ff    <= '0;
         cmp_idx_ff <= '0;
         pend_ff    <= 1'b0;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         used_ff    <= used_in;
         cmp_idx_ff <= cmp_idx_in;
         pend_ff    <= pend_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

endmodule

// File: hdl/sra_datapath.sv
// ----------------------------------------------------------------------------
// sra_datapath
// Request capture, entry update, serial divider, clamp, distance table and
// result registers.
// ----------------------------------------------------------------------------
module sra_datapath #(
   parameter int MAX_READINGS    = sra_pkg::DEF_MAX_READINGS,
   parameter int EXPONENT_TENTHS = sra_pkg::DEF_EXPONENT_TENTHS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sra_pkg::sra_cmd_type                   cmd,
   output sra_pkg::sra_status_type                status,
   input  logic [sra_pkg::MAC_W-1:0]              req_mac,
   input  logic                                   req_rssi_present,
   input  logic signed [sra_pkg::RSSI_W-1:0]      req_rssi_dbm,
   input  logic                                   csr_we,
   input  logic [sra_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [sra_pkg::CSR_W-1:0]              csr_wdata,
   input  logic [sra_pkg::ENTRY_W-1:0]            rd_data,
   output logic [sra_pkg::ENTRY_W-1:0]            wr_data,
   output logic                                   rsp_strobe,
   output logic [sra_pkg::MAC_W-1:0]              rsp_station_mac,
   output logic                                   rsp_station_valid,
   output logic [sra_pkg::CNT_W-1:0]              rsp_samples_held,
   output logic                                   rsp_has_samples,
   output logic signed [sra_pkg::RSSI_W-1:0]      rsp_avg_rssi_dbm,
   output logic [sra_pkg::DIST_W-1:0]             rsp_distance_q8,
   output logic                                   rsp_last
);
   import sra_pkg::*;

   localparam real          DB_STEP  = 1.0 / real'(EXPONENT_TENTHS);
   localparam dist_rom_type DIST_ROM = build_dist_rom(DB_STEP);

   logic [MAC_W-1:0]         mac_ff;
   logic                     present_ff;
   logic signed [RSSI_W-1:0] rssi_ff;
   logic signed [RSSI_W-1:0] tx_ff;
   logic [CSR_W-1:0]         pl_ff;

   logic [MAC_W-1:0]         ent_key_ff;
   logic signed [SUM_W-1:0]  ent_sum_ff;
   logic [CNT_W-1:0]         ent_cnt_ff;

   logic [SUM_W-1:0]         mag_ff, mag_in;
   logic [CNT_W-1:0]         rem_ff, rem_in;
   logic                     neg_ff;
   logic [CNT_W:0]           trial;

   logic signed [RSSI_W-1:0] avg_ff;
   logic [7:0]               rom_idx_ff;
   logic signed [SUM_W-1:0]  avg_full;
   logic signed [10:0]       x_db;
   logic signed [10:0]       x_cl;

   logic signed [SUM_W-1:0]  rssi_ext;
   logic                     has;

   logic                     strobe_ff;
   logic [MAC_W-1:0]         o_mac_ff;
   logic                     o_valid_ff;
   logic [CNT_W-1:0]         o_cnt_ff;
   logic                     o_has_ff;
   logic signed [RSSI_W-1:0] o_avg_ff;
   logic [DIST_W-1:0]        o_dist_ff;
   logic                     o_last_ff;

   assign rssi_ext = SUM_W'(rssi_ff);

   assign status.key_match = (rd_data[ENTRY_W-1 -: MAC_W] == mac_ff);
   assign status.upd_ok    = present_ff && (ent_cnt_ff < CNT_W'(MAX_READINGS));

   always_comb begin
      if (cmd.wr_insert) begin
         wr_data = {mac_ff, present_ff ? rssi_ext : {SUM_W{1'b0}}, CNT_W'(present_ff)};
      end else begin
         wr_data = {ent_key_ff, SUM_W'(ent_sum_ff + rssi_ext), ent_cnt_ff + CNT_W'(1)};
      end
   end

   // restoring divide: shift one quotient bit into the magnitude per step
   assign trial = {rem_ff, mag_ff[SUM_W-1]} - {1'b0, ent_cnt_ff};

   always_comb begin
      mag_in = mag_ff;
      rem_in = rem_ff;
      if (cmd.div_init) begin
         mag_in = rd_data[CNT_W +: SUM_W];
         if (rd_data[ENTRY_W-MAC_W-1]) begin
            mag_in = SUM_W'(-rd_data[CNT_W +: SUM_W]);
         end
         rem_in = '0;
      end else if (cmd.div_step) begin
         if (!trial[CNT_W]) begin
            rem_in = trial[CNT_W-1:0];
            mag_in = {mag_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[CNT_W-2:0], mag_ff[SUM_W-1]};
            mag_in = {mag_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      avg_full = neg_ff ? SUM_W'(-mag_ff) : mag_ff;
      x_db     = 11'(tx_ff) - 11'(signed'(avg_full[RSSI_W-1:0])) - 11'(pl_ff);
      if (x_db > 11'sd120) begin
         x_cl = 11'sd120;
      end else if (x_db < -11'sd120) begin
         x_cl = -11'sd120;
      end else begin
         x_cl = x_db;
      end
   end

   assign has = (ent_cnt_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ff     <= TX_POWER_RESET;
         pl_ff     <= PATH_LOSS_RESET;
         strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_TX_POWER:  tx_ff <= signed'(csr_wdata);
               CSR_PATH_LOSS: pl_ff <= csr_wdata;
               default: ;
            endcase
         end
         strobe_ff <= cmd.out_load;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mac_ff     <= req_mac;
         present_ff <= req_rssi_present;
         rssi_ff    <= req_rssi_dbm;
      end
      if (cmd.cap_entry) begin
         ent_key_ff <= rd_data[ENTRY_W-1 -: MAC_W];
         ent_sum_ff <= signed'(rd_data[CNT_W +: SUM_W]);
         ent_cnt_ff <= rd_data[CNT_W-1:0];
      end
      if (cmd.div_init) begin
         neg_ff <= rd_data[ENTRY_W-MAC_W-1];
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      if (cmd.clamp_load) begin
         avg_ff     <= avg_full[RSSI_W-1:0];
         rom_idx_ff <= 8'(x_cl + 11'sd120);
      end
      if (cmd.out_load) begin
         o_last_ff <= cmd.out_last;
         if (cmd.out_empty) begin
            o_mac_ff   <= '0;
            o_valid_ff <= 1'b0;
            o_cnt_ff   <= '0;
            o_has_ff   <= 1'b0;
            o_avg_ff   <= '0;
            o_dist_ff  <= '0;
         end else begin
            o_mac_ff   <= ent_key_ff;
            o_valid_ff <= 1'b1;
            o_cnt_ff   <= ent_cnt_ff;
            o_has_ff   <= has;
            o_avg_ff   <= has ? avg_ff : '0;
            o_dist_ff  <= has ? DIST_ROM[rom_idx_ff] : '0;
         end
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_station_mac   = o_mac_ff;
   assign rsp_station_valid = o_valid_ff;
   assign rsp_samples_held  = o_cnt_ff;
   assign rsp_has_samples   = o_has_ff;
   assign rsp_avg_rssi_dbm  = o_avg_ff;
   assign rsp_distance_q8   = o_dist_ff;
   assign rsp_last          = o_last_ff;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the station signal-strength table. Sample and dump
// beats go in through the start/busy handshake; every strobed report is
// checked against an in-bench table model with its own path-loss distance
// table, over several transmit-power and reference-loss settings.
// ----------------------------------------------------------------------------
module testbench;
   import sra_pkg::*;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_DUMP   = 1'b1;
   localparam int   STATIONS  = DEF_MAX_STATIONS;
   localparam int   READINGS  = DEF_MAX_READINGS;
   localparam int   MAC_POOL  = 72;
   localparam int   DRAIN     = 100;

   typedef struct {
      logic              op;
      logic [MAC_W-1:0]  mac;
      logic              present;
      logic [RSSI_W-1:0] rssi;
   } sighting_type;

   typedef struct packed {
      logic [MAC_W-1:0]  mac;
      logic              valid;
      logic [CNT_W-1:0]  held;
      logic              has;
      logic [RSSI_W-1:0] avg;
      logic [DIST_W-1:0] dist_q8;
      logic              last;
   } report_type;

   typedef struct {
      sighting_type s;
      logic         typed;
      report_type   r;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_op = OP_SAMPLE;
   logic [MAC_W-1:0] req_mac = '0;
   logic req_rssi_present = 1'b0;
   logic signed [RSSI_W-1:0] req_rssi_dbm = '0;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TX_POWER;
   logic [CSR_W-1:0] csr_wdata = '0;
   logic rsp_strobe;
   logic [MAC_W-1:0] rsp_station_mac;
   logic rsp_station_valid;
   logic [CNT_W-1:0] rsp_samples_held;
   logic rsp_has_samples;
   logic signed [RSSI_W-1:0] rsp_avg_rssi_dbm;
   logic [DIST_W-1:0] rsp_distance_q8;
   logic rsp_last;

   station_rssi_average_ranging DUT (.*);

   always #2 clock = ~clock;

   initial begin
      #5000000;
      $display("FAILED: results differ");
      $finish;
   end

   // table model
   logic [MAC_W-1:0]  stn_mac [STATIONS];
   int                stn_sum [STATIONS];
   int                stn_cnt [STATIONS];
   int                stn_used = 0;
   int                tx_dbm = 20;
   int                ref_loss = 40;
   logic [DIST_W-1:0] range_q8 [-DB_CLAMP:DB_CLAMP];
   report_type        pending_reports [$];
   logic [MAC_W-1:0]  mac_pool [MAC_POOL];

   int errors = 0;
   int beats_in = 0;
   int reports_seen = 0;
   int dumps_in = 0;
   int gap_pct = 0;

   function automatic logic [DIST_W-1:0] range_for(int x);
      real r;
      r = 256.0 * (10.0 ** (real'(x) / real'(DEF_EXPONENT_TENTHS)));
      if (r >= 4194303.0) return DIST_MAX;
      return DIST_W'($rtoi(r + 0.5));
   endfunction

   // advance the table model by one accepted beat, queue its reports
   task automatic apply_sighting(sighting_type s, logic keep);
      int i;
      int avg;
      int x;
      report_type r;
      if (s.op == OP_SAMPLE) begin
         for (i = 0; i < stn_used; i++)
            if (stn_mac[i] == s.mac) break;
         if (i == stn_used) begin
            if (stn_used >= STATIONS) return;
            stn_mac[i] = s.mac;
            stn_sum[i] = 0;
            stn_cnt[i] = 0;
            stn_used++;
         end
         if (s.present && stn_cnt[i] < READINGS) begin
            stn_sum[i] += int'($signed(s.rssi));
            stn_cnt[i]++;
         end
      end else if (keep) begin
         if (stn_used == 0) begin
            r = '0;
            r.last = 1'b1;
            pending_reports.push_back(r);
         end
         for (i = 0; i < stn_used; i++) begin
            r = '0;
            r.mac = stn_mac[i];
            r.valid = 1'b1;
            r.held = CNT_W'(stn_cnt[i]);
            r.last = (i == stn_used - 1);
            if (stn_cnt[i] != 0) begin
               avg = stn_sum[i] / stn_cnt[i];
               x = tx_dbm - avg - ref_loss;
               if (x > DB_CLAMP) x = DB_CLAMP;
               if (x < -DB_CLAMP) x = -DB_CLAMP;
               r.has = 1'b1;
               r.avg = RSSI_W'(avg);
               r.dist_q8 = range_q8[x];
            end
            pending_reports.push_back(r);
         end
      end
   endtask

   // start stays high between back-to-back beats; lower it only for a gap
   task automatic issue(sighting_type s, logic keep);
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_op <= s.op;
      req_mac <= s.mac;
      req_rssi_present <= s.present;
      req_rssi_dbm <= s.rssi;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      beats_in++;
      if (s.op == OP_DUMP) dumps_in++;
      apply_sighting(s, keep);
   endtask

   // hold off until all reports are back and any sample beat has finished
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0 || busy) @(posedge clock);
      repeat (STATIONS + 8) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_TX_POWER) tx_dbm = int'($signed(val));
      else ref_loss = int'(val);
      @(posedge clock);
   endtask

   task automatic random_burst(int n);
      sighting_type s;
      repeat (n) begin
         s.op = ($urandom_range(99) < 8) ? OP_DUMP : OP_SAMPLE;
         s.mac = (s.op == OP_DUMP || $urandom_range(9) == 0) ?
                 {$urandom, $urandom} : mac_pool[$urandom_range(MAC_POOL - 1)];
         s.present = ($urandom_range(9) != 0);
         s.rssi = RSSI_W'($urandom);
         issue(s, 1'b1);
      end
   endtask

   always @(posedge clock) begin
      report_type got;
      report_type want;
      if (!reset && rsp_strobe) begin
         reports_seen++;
         got = {rsp_station_mac, rsp_station_valid, rsp_samples_held,
                rsp_has_samples, rsp_avg_rssi_dbm, rsp_distance_q8, rsp_last};
         if (pending_reports.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected report beat mac=%h", got.mac);
         end else begin
            want = pending_reports.pop_front();
            if (got.mac !== want.mac || got.valid !== want.valid ||
                got.held !== want.held || got.has !== want.has ||
                got.avg !== want.avg || got.dist_q8 !== want.dist_q8 ||
                got.last !== want.last) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch exp mac=%h v=%b n=%0d h=%b avg=%0d d=%0d l=%b",
                            " / got mac=%h v=%b n=%0d h=%b avg=%0d d=%0d l=%b"},
                           want.mac, want.valid, want.held, want.has,
                           $signed(want.avg), want.dist_q8, want.last,
                           got.mac, got.valid, got.held, got.has,
                           $signed(got.avg), got.dist_q8, got.last);
            end
         end
      end
   end

   row_type rows [$];

   function automatic row_type row(logic op, logic [MAC_W-1:0] mac, logic p,
                                   logic [RSSI_W-1:0] rssi);
      row_type t;
      t.s = '{op, mac, p, rssi};
      t.typed = 1'b0;
      t.r = '0;
      return t;
   endfunction

   initial begin
      row_type t;
      int cap;
      for (int x = -DB_CLAMP; x <= DB_CLAMP; x++) range_q8[x] = range_for(x);
      for (int i = 0; i < MAC_POOL; i++) mac_pool[i] = {$urandom, $urandom};

      // empty table: one flagged beat, everything else zero
      t = row(OP_DUMP, 48'h0, 1'b0, 8'h00);
      t.typed = 1'b1;
      t.r.last = 1'b1;
      rows.push_back(t);
      rows.push_back(row(OP_SAMPLE, 48'h0, 1'b0, 8'h7F));   // sighting with no reading
      rows.push_back(row(OP_SAMPLE, '1, 1'b1, 8'h80));
      rows.push_back(row(OP_SAMPLE, '1, 1'b1, 8'h7F));
      rows.push_back(row(OP_SAMPLE, '1, 1'b1, 8'hFF));
      rows.push_back(row(OP_DUMP, '1, 1'b1, 8'h80));        // dump ignores payload
      for (int i = 0; i < READINGS + 2; i++)                // run past the reading limit
         rows.push_back(row(OP_SAMPLE, 48'hA5A5_5A5A_0F0F, 1'b1, 8'h80));
      rows.push_back(row(OP_SAMPLE, 48'h0, 1'b1, 8'h00));
      rows.push_back(row(OP_DUMP, 48'h0, 1'b0, 8'h00));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         issue(rows[i].s, !rows[i].typed);
         if (rows[i].typed) pending_reports.push_back(rows[i].r);
      end
      settle();

      // several settings, extremes included; idling varies per phase
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin write_reg(CSR_TX_POWER, 8'd127); write_reg(CSR_PATH_LOSS, 8'd0); end
            1: begin write_reg(CSR_TX_POWER, 8'h80); write_reg(CSR_PATH_LOSS, 8'd255); end
            2: begin write_reg(CSR_TX_POWER, 8'd20); write_reg(CSR_PATH_LOSS, 8'd40); end
            default: begin
               write_reg(CSR_TX_POWER, CSR_W'($urandom));
               write_reg(CSR_PATH_LOSS, CSR_W'($urandom_range(30, 90)));
            end
         endcase
         gap_pct = (ph == 1) ? 45 : (ph == 3) ? 10 : 0;
         cap = 50;
         random_burst(cap);
         // close every phase with a full report of the table
         issue('{OP_DUMP, '0, 1'b0, '0}, 1'b1);
         settle();
      end

      start <= 1'b0;
      repeat (DRAIN) @(posedge clock);
      if (pending_reports.size() != 0) begin
         errors++;
         $display("%0d report beats never arrived", pending_reports.size());
      end
      $display("covered %0d input beats (%0d dumps), %0d report beats, %0d stations held",
               beats_in, dumps_in, reports_seen, stn_used);
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
